FILE: rtl/cau_pkg.sv
// Package: shared types and constants for the CSR access unit.
`default_nettype none

package cau_pkg;

    localparam int DATA_W      = 32;
    localparam int CSR_ADDR_W  = 12;
    localparam int CSR_DEPTH   = 1 << CSR_ADDR_W;
    localparam int REG_IDX_W   = 5;
    localparam int STATUS_W    = 2;

    localparam logic [6:0] SYSTEM_OPCODE = 7'b1110011;
    localparam logic [1:0] RO_BITS       = 2'b11;

    // funct3[1:0] kinds
    localparam logic [1:0] KIND_NONE  = 2'b00;
    localparam logic [1:0] KIND_WRITE = 2'b01;
    localparam logic [1:0] KIND_SET   = 2'b10;
    localparam logic [1:0] KIND_CLEAR = 2'b11;

    localparam logic OP_EXECUTE = 1'b0;
    localparam logic OP_INSTALL = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_CSR   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ABSENT    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_READ_ONLY = 2'd3;

    typedef struct packed {
        logic                  operation;
        logic [DATA_W-1:0]     instruction;
        logic [DATA_W-1:0]     source_value;
        logic [CSR_ADDR_W-1:0] install_address;
        logic [DATA_W-1:0]     install_value;
    } cau_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [DATA_W-1:0]    read_value;
        logic                 dest_write;
        logic [REG_IDX_W-1:0] dest_index;
    } cau_rsp_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic                  capture;
        logic                  read_en;
        logic                  exec;
        logic                  clear_en;
        logic [CSR_ADDR_W-1:0] clear_addr;
    } cau_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/cau_ctrl.sv
// Controller: presence clear sweep and per-beat sequencing.
`default_nettype none

module cau_ctrl
    import cau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    output logic          done,
    output cau_cmd_t      cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CSR_ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic                  done_reg, done_next;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        cmd.capture    = (state_reg == S_IDLE) && start;
        cmd.read_en    = (state_reg == S_READ);
        cmd.exec       = (state_reg == S_EXEC);
        cmd.clear_en   = (state_reg == S_CLEAR);
        cmd.clear_addr = clr_cnt_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/cau_dp.sv
// Datapath: CSR value and presence stores, decode and read-modify-write.
`default_nettype none

module cau_dp
    import cau_pkg::*;
(
    input  wire logic     clk,
    input  wire cau_req_t request,
    input  wire cau_cmd_t cmd,
    output cau_rsp_t      response
);

    logic [DATA_W-1:0] val_mem [0:CSR_DEPTH-1];
    logic              pres_mem [0:CSR_DEPTH-1];

    cau_req_t          req_reg;
    logic [DATA_W-1:0] val_rd_reg;
    logic              pres_rd_reg;
    cau_rsp_t          rsp_reg, rsp_next;

    logic [6:0]            opcode;
    logic [REG_IDX_W-1:0]  rd;
    logic [2:0]            funct3;
    logic [REG_IDX_W-1:0]  rs1f;
    logic [CSR_ADDR_W-1:0] addr;
    logic [1:0]            kind;
    logic [DATA_W-1:0]     src;
    logic [DATA_W-1:0]     new_val;
    logic                  not_csr;
    logic                  writes;
    logic                  read_only;

    logic                  val_we;
    logic [CSR_ADDR_W-1:0] val_waddr;
    logic [DATA_W-1:0]     val_wdata;
    logic                  pres_we;
    logic [CSR_ADDR_W-1:0] pres_waddr;
    logic                  pres_wdata;

    assign opcode = req_reg.instruction[6:0];
    assign rd     = req_reg.instruction[11:7];
    assign funct3 = req_reg.instruction[14:12];
    assign rs1f   = req_reg.instruction[19:15];
    assign addr   = req_reg.instruction[31:20];
    assign kind   = funct3[1:0];

    always_comb
    begin
        not_csr   = (opcode != SYSTEM_OPCODE) || (kind == KIND_NONE);
        src       = funct3[2] ? {{(DATA_W-REG_IDX_W){1'b0}}, rs1f} : req_reg.source_value;
        writes    = (kind == KIND_WRITE) || (rs1f != '0);
        read_only = (addr[CSR_ADDR_W-1:CSR_ADDR_W-2] == RO_BITS);
        case (kind)
            KIND_WRITE: new_val = src;
            KIND_SET:   new_val = val_rd_reg | src;
            KIND_CLEAR: new_val = val_rd_reg & ~src;
            default:    new_val = val_rd_reg;
        endcase

        rsp_next.status     = STAT_OK;
        rsp_next.read_value = '0;
        rsp_next.dest_write = 1'b0;
        rsp_next.dest_index = rd;
        val_we              = 1'b0;
        if (req_reg.operation == OP_INSTALL)
        begin
            rsp_next.dest_index = '0;
            val_we              = 1'b1;
        end
        else if (not_csr)
        begin
            rsp_next.status = STAT_NOT_CSR;
        end
        else if (!pres_rd_reg)
        begin
            rsp_next.status = STAT_ABSENT;
        end
        else if (writes && read_only)
        begin
            rsp_next.status = STAT_READ_ONLY;
        end
        else
        begin
            rsp_next.read_value = val_rd_reg;
            rsp_next.dest_write = (rd != '0);
            val_we              = writes;
        end
        val_we = val_we && cmd.exec;
    end

    // one write port per store; install and clear sweep share the presence port
    always_comb
    begin
        if (req_reg.operation == OP_INSTALL)
        begin
            val_waddr = req_reg.install_address;
            val_wdata = req_reg.install_value;
        end
        else
        begin
            val_waddr = addr;
            val_wdata = new_val;
        end
        pres_we    = cmd.clear_en || (cmd.exec && (req_reg.operation == OP_INSTALL));
        pres_waddr = cmd.clear_en ? cmd.clear_addr : req_reg.install_address;
        pres_wdata = !cmd.clear_en;
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (cmd.read_en)
        begin
            val_rd_reg <= val_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pres_we)
        begin
            pres_mem[pres_waddr] <= pres_wdata;
        end
        if (cmd.read_en)
        begin
            pres_rd_reg <= pres_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign response = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/csr_access_unit.sv
// Top level: RV32 Zicsr CSR access unit.
`default_nettype none

// Usage
//   Request channel: drive request and raise start; a beat is taken at a
//   rising edge where start is high and busy is low. The request either
//   installs a CSR (marks it present with a value) or executes one Zicsr
//   instruction, with source_value standing for rs1.
//   Response channel: done is high for exactly one cycle with the result
//   beat on response (status, old CSR value, rd write enable, rd index).
//   The receiver cannot stall; it must take the beat in that cycle.
// Timing
//   The accepting edge registers the beat, S_READ reads the value and
//   presence stores, S_EXEC computes and writes back, and done is high
//   in the cycle busy goes low again, so one beat is taken at a time; the
//   store's single registered read port followed by write-back sets this.
// Reset
//   After rst_n releases, the presence store is swept to zero, one entry a
//   cycle through all 4096 entries; busy stays high during the sweep. The
//   value store is not cleared: a value is only used once installed.

module csr_access_unit
    import cau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire cau_req_t request,
    output logic          busy,
    output logic          done,
    output cau_rsp_t      response
);

    cau_cmd_t cmd;

    // sequencing and presence clear sweep
    cau_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // stores, decode and read-modify-write
    cau_dp u_dp (
        .clk      (clk),
        .request  (request),
        .cmd      (cmd),
        .response (response)
    );

endmodule

`default_nettype wire

FILE: tb/tb_csr_access_unit.sv
// Testbench for csr_access_unit: directed and random Zicsr traffic with in-order result checks.
`timescale 1ns / 1ps

module tb_csr_access_unit;
    import cau_pkg::*;

    // funct3 encodings of the SYSTEM opcode
    localparam logic [2:0] F3_PRIV   = 3'b000;
    localparam logic [2:0] F3_CSRRW  = 3'b001;
    localparam logic [2:0] F3_CSRRS  = 3'b010;
    localparam logic [2:0] F3_CSRRC  = 3'b011;
    localparam logic [2:0] F3_RSVD   = 3'b100;
    localparam logic [2:0] F3_CSRRWI = 3'b101;
    localparam logic [2:0] F3_CSRRSI = 3'b110;
    localparam logic [2:0] F3_CSRRCI = 3'b111;

    // an ordinary register-register ALU opcode, never a CSR access
    localparam logic [6:0] OPC_ALU_REG = 7'b0110011;

    // The presence sweep after reset keeps busy high while it clears all
    // entries, so the watchdog must comfortably outlast it.
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int DRAIN_LIMIT    = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_BEATS   = 1650;
    localparam int PHASE_BEATS    = 150;
    localparam int REPORT_LIMIT   = 10;

    logic     clk;
    logic     rst_n;
    logic     start;
    cau_req_t request;
    logic     busy;
    logic     done;
    cau_rsp_t response;

    csr_access_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .response (response)
    );

    // Shadow copy of the CSR file: values and presence bits.
    logic [DATA_W-1:0] shadow_value   [CSR_DEPTH];
    bit                shadow_present [CSR_DEPTH];

    // Responses predicted at acceptance, consumed in order as done pulses.
    cau_rsp_t pending_responses [$];

    // Addresses handed out by installs; the random traffic mostly aims here.
    logic [CSR_ADDR_W-1:0] installed_addrs [$];

    int mismatches;
    int gap_pct;

    //------------------------------------------------------------------
    // Clock
    //------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    //------------------------------------------------------------------
    // Predictor: the response one beat produces, with the shadow update.
    //------------------------------------------------------------------
    function automatic cau_rsp_t csr_access_outcome(input cau_req_t r);
        cau_rsp_t              rsp;
        logic [6:0]            opc;
        logic [4:0]            rd;
        logic [4:0]            rs1f;
        logic [2:0]            f3;
        logic [1:0]            kind;
        logic [CSR_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]     src;
        logic [DATA_W-1:0]     old;
        logic                  writes;

        rsp = '0;
        if (r.operation == OP_INSTALL)
        begin
            shadow_present[r.install_address] = 1'b1;
            shadow_value[r.install_address]   = r.install_value;
            return rsp;
        end

        opc  = r.instruction[6:0];
        rd   = r.instruction[11:7];
        f3   = r.instruction[14:12];
        rs1f = r.instruction[19:15];
        addr = r.instruction[31:20];
        kind = f3[1:0];
        rsp.dest_index = rd;

        // Fault order: not a CSR op, then absent entry, then read-only write.
        if (opc != SYSTEM_OPCODE || kind == KIND_NONE)
        begin
            rsp.status = STAT_NOT_CSR;
            return rsp;
        end
        if (!shadow_present[addr])
        begin
            rsp.status = STAT_ABSENT;
            return rsp;
        end

        // funct3[2] selects the zero-extended uimm in place of rs1's value
        src    = f3[2] ? {{(DATA_W-5){1'b0}}, rs1f} : r.source_value;
        // set/clear with a zero rs1 field is a pure read
        writes = (kind == KIND_WRITE) || (rs1f != 5'd0);
        if (writes && addr[11:10] == RO_BITS)
        begin
            rsp.status = STAT_READ_ONLY;
            return rsp;
        end

        old = shadow_value[addr];
        if (writes)
        begin
            case (kind)
                KIND_WRITE: shadow_value[addr] = src;
                KIND_SET:   shadow_value[addr] = old | src;
                default:    shadow_value[addr] = old & ~src;
            endcase
        end
        rsp.status     = STAT_OK;
        rsp.read_value = old;
        rsp.dest_write = (rd != 5'd0);
        return rsp;
    endfunction

    //------------------------------------------------------------------
    // Monitor and scoreboard. Inputs move on the falling edge, so at the
    // rising edge start/request are stable and busy/done still hold the
    // values of the cycle that is ending.
    //------------------------------------------------------------------
    always @(posedge clk)
    begin : track_results
        cau_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with nothing expected: st=%0d val=%h we=%0b rd=%0d",
                             $realtime, response.status, response.read_value,
                             response.dest_write, response.dest_index);
            end
            else
            begin
                want = pending_responses.pop_front();
                if (response.status     !== want.status     ||
                    response.read_value !== want.read_value ||
                    response.dest_write !== want.dest_write ||
                    response.dest_index !== want.dest_index)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: mismatch exp st=%0d val=%h we=%0b rd=%0d | got st=%0d val=%h we=%0b rd=%0d",
                                 $realtime, want.status, want.read_value, want.dest_write,
                                 want.dest_index, response.status, response.read_value,
                                 response.dest_write, response.dest_index);
                end
            end
        end
        // a beat is taken at this edge: predict its response now
        if (rst_n && start && !busy)
            pending_responses.push_back(csr_access_outcome(request));
    end

    //------------------------------------------------------------------
    // Watchdog: cycles with neither a beat taken nor a result seen.
    //------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    //------------------------------------------------------------------
    // Beat driver: optional idle gap, then hold start until taken.
    //------------------------------------------------------------------
    task automatic send_beat(input cau_req_t r);
        int idle;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            idle = $urandom_range(1, 4);
            repeat (idle)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic cau_req_t csr_exec_beat(input logic [2:0] f3,
                                               input logic [CSR_ADDR_W-1:0] addr,
                                               input logic [4:0] rs1f,
                                               input logic [4:0] rd,
                                               input logic [DATA_W-1:0] src);
        cau_req_t r;
        r = '0;
        r.operation    = OP_EXECUTE;
        r.instruction  = {addr, rs1f, f3, rd, SYSTEM_OPCODE};
        r.source_value = src;
        return r;
    endfunction

    task automatic install_csr(input logic [CSR_ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] value);
        cau_req_t r;
        r = '0;
        r.operation       = OP_INSTALL;
        r.install_address = addr;
        r.install_value   = value;
        installed_addrs.push_back(addr);
        send_beat(r);
    endtask

    //------------------------------------------------------------------
    // Directed tests
    //------------------------------------------------------------------

    // Nothing installed yet, plus words that are not CSR accesses at all.
    task automatic test_absent_and_malformed();
        cau_req_t r;
        send_beat(csr_exec_beat(F3_CSRRW, 12'h300, 5'd1, 5'd1, 32'h1234_5678));
        r = csr_exec_beat(F3_CSRRW, 12'h300, 5'd1, 5'd3, 32'h0);
        r.instruction[6:0] = OPC_ALU_REG;
        send_beat(r);
        send_beat(csr_exec_beat(F3_PRIV, 12'h000, 5'd0, 5'd31, 32'h0));
        send_beat(csr_exec_beat(F3_RSVD, 12'hFFF, 5'd31, 5'd7, 32'hFFFF_FFFF));
    endtask

    // Corners of the address range, both inside and outside the read-only block.
    task automatic test_install();
        install_csr(12'h000, 32'hFFFF_FFFF);
        install_csr(12'hFFF, 32'h0000_0000);
        install_csr(12'hC00, 32'hA5A5_5A5A);
        install_csr(12'h300, 32'h0000_0000);
    endtask

    task automatic test_register_forms();
        send_beat(csr_exec_beat(F3_CSRRW, 12'h300, 5'd9,  5'd31, 32'hFFFF_FFFF));
        // rs1 field zero: no write even though source_value is not zero
        send_beat(csr_exec_beat(F3_CSRRS, 12'h300, 5'd0,  5'd5,  32'h0000_1234));
        // rd = x0: the CSR still updates, rd is not written
        send_beat(csr_exec_beat(F3_CSRRC, 12'h300, 5'd3,  5'd0,  32'h0000_FFFF));
        send_beat(csr_exec_beat(F3_CSRRS, 12'h000, 5'd7,  5'd2,  32'h0000_0000));
        send_beat(csr_exec_beat(F3_CSRRW, 12'h300, 5'd31, 5'd1,  32'h0000_0000));
    endtask

    task automatic test_immediate_forms();
        send_beat(csr_exec_beat(F3_CSRRWI, 12'h000, 5'd31,  5'd4,  32'hFFFF_FFFF));
        send_beat(csr_exec_beat(F3_CSRRSI, 12'h000, 5'd0,   5'd6,  32'hFFFF_FFFF));
        send_beat(csr_exec_beat(F3_CSRRSI, 12'h300, 5'h10,  5'd8,  32'h0));
        send_beat(csr_exec_beat(F3_CSRRCI, 12'h000, 5'd31,  5'd10, 32'h0));
    endtask

    // Writes to the read-only block fault; pure reads of it go through.
    task automatic test_read_only();
        send_beat(csr_exec_beat(F3_CSRRW,  12'hC00, 5'd0,  5'd11, 32'h0));
        send_beat(csr_exec_beat(F3_CSRRS,  12'hC00, 5'd0,  5'd12, 32'hFFFF_FFFF));
        send_beat(csr_exec_beat(F3_CSRRSI, 12'hFFF, 5'd0,  5'd13, 32'h0));
        send_beat(csr_exec_beat(F3_CSRRCI, 12'hFFF, 5'd1,  5'd14, 32'h0));
        send_beat(csr_exec_beat(F3_CSRRC,  12'hC00, 5'd31, 5'd15, 32'hFFFF_FFFF));
        send_beat(csr_exec_beat(F3_CSRRWI, 12'hFFF, 5'd0,  5'd16, 32'h0));
        // re-install replaces the value
        install_csr(12'hC00, 32'hFFFF_FFFF);
        send_beat(csr_exec_beat(F3_CSRRS,  12'hC00, 5'd0,  5'd17, 32'h0));
    endtask

    //------------------------------------------------------------------
    // Random traffic: mostly well-formed CSR ops on installed entries,
    // some installs, some junk words. Idle rate rotates every phase.
    //------------------------------------------------------------------
    task automatic test_random_traffic(input int beats);
        int                    pct_cycle [3];
        logic [2:0]            csr_f3 [6];
        cau_req_t              r;
        logic [2:0]            f3;
        logic [CSR_ADDR_W-1:0] addr;
        logic [4:0]            rs1f;
        logic [4:0]            rd;
        int                    pick;

        pct_cycle = '{0, 57, 26};
        csr_f3    = '{F3_CSRRW, F3_CSRRS, F3_CSRRC, F3_CSRRWI, F3_CSRRSI, F3_CSRRCI};

        for (int n = 0; n < beats; n++)
        begin
            gap_pct = pct_cycle[(n / PHASE_BEATS) % 3];

            r.operation       = OP_EXECUTE;
            r.instruction     = $urandom;
            r.source_value    = $urandom;
            r.install_address = CSR_ADDR_W'($urandom);
            r.install_value   = $urandom;

            pick = $urandom_range(99);
            if (pick < 15)
            begin
                // new entry anywhere, in the read-only block, or a re-install
                case ($urandom_range(3))
                    0:       addr = {RO_BITS, 10'($urandom)};
                    1:       addr = installed_addrs[$urandom_range(installed_addrs.size() - 1)];
                    default: addr = CSR_ADDR_W'($urandom);
                endcase
                case ($urandom_range(7))
                    0:       r.install_value = '0;
                    1:       r.install_value = '1;
                    default: r.install_value = $urandom;
                endcase
                r.operation       = OP_INSTALL;
                r.install_address = addr;
                installed_addrs.push_back(addr);
            end
            else if (pick < 85)
            begin
                f3   = csr_f3[$urandom_range(5)];
                addr = ($urandom_range(9) < 8)
                       ? installed_addrs[$urandom_range(installed_addrs.size() - 1)]
                       : CSR_ADDR_W'($urandom);
                rs1f = ($urandom_range(4) == 0) ? 5'd0 : 5'($urandom);
                rd   = ($urandom_range(7) == 0) ? 5'd0 : 5'($urandom);
                r.instruction = {addr, rs1f, f3, rd, SYSTEM_OPCODE};
                case ($urandom_range(7))
                    0:       r.source_value = '0;
                    1:       r.source_value = '1;
                    default: r.source_value = $urandom;
                endcase
            end
            else if ($urandom_range(1) == 0)
            begin
                // SYSTEM opcode with any funct3, privileged/reserved included
                r.instruction[6:0] = SYSTEM_OPCODE;
            end
            send_beat(r);
        end
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------
    initial
    begin : run
        int drain;

        mismatches = 0;
        gap_pct    = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        for (int i = 0; i < CSR_DEPTH; i++)
        begin
            shadow_present[i] = 1'b0;
            shadow_value[i]   = '0;
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // the presence sweep just holds busy; send_beat waits it out
        test_absent_and_malformed();
        test_install();
        test_register_forms();
        test_immediate_forms();
        test_read_only();
        test_random_traffic(RANDOM_BEATS);

        @(negedge clk);
        start <= 1'b0;

        drain = 0;
        while (pending_responses.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        // catch any stray result trailing the last one
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_responses.size() != 0)
        begin
            mismatches += pending_responses.size();
            $display("%0d expected results never arrived", pending_responses.size());
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: csr_access_unit.f
rtl/cau_pkg.sv
rtl/cau_ctrl.sv
rtl/cau_dp.sv
rtl/csr_access_unit.sv
tb/tb_csr_access_unit.sv
